### rtl/core/lrk4_pkg.sv
// Shared types and constants for the Lorenz RK4 integrator
`default_nettype none
package lrk4_pkg;
    localparam int FRAC_BITS_DEF   = 20;
    localparam int STATE_WIDTH_DEF = 32;

    localparam logic [20:0] STEP_RST  = 21'd10486;
    localparam logic [30:0] SIGMA_RST = 31'd10485760;
    localparam logic [30:0] RHO_RST   = 31'd29360128;
    localparam logic [30:0] BETA_RST  = 31'd2796203;
    localparam logic [15:0] INTV_RST  = 16'd1;

    localparam logic signed [31:0] POS_X_RST = 32'sd1048576;
    localparam logic signed [31:0] POS_Y_RST = 32'sd524288;
    localparam logic signed [31:0] POS_Z_RST = -32'sd314573;

    localparam logic ACT_STEP = 1'b0;
    localparam logic ACT_LOAD = 1'b1;

    typedef enum logic [2:0] {
        CFG_STEP  = 3'd0,
        CFG_SIGMA = 3'd1,
        CFG_RHO   = 3'd2,
        CFG_BETA  = 3'd3,
        CFG_INTV  = 3'd4
    } t_cfg_idx;

    typedef struct packed {
        logic done;
        logic clip;
    } t_mul_stat;
endpackage
`default_nettype wire

### rtl/core/lrk4_mul.sv
// Shared fixed-point multiplier: exact product, truncating shift, saturation
`default_nettype none
module lrk4_mul #(
    parameter int FRAC_BITS   = lrk4_pkg::FRAC_BITS_DEF,
    parameter int STATE_WIDTH = lrk4_pkg::STATE_WIDTH_DEF,
    parameter int OW          = 32
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_start,
    input  wire logic signed [OW-1:0]          i_a,
    input  wire logic signed [OW-1:0]          i_b,
    output logic signed [STATE_WIDTH-1:0]      o_res,
    output lrk4_pkg::t_mul_stat                o_stat
);
    import lrk4_pkg::*;

    localparam int PW = 2 * OW;

    logic [OW-1:0] mag_a;
    logic [OW-1:0] mag_b;
    logic [PW-1:0] r_prod;
    logic          r_neg;
    logic          r_vld1;
    logic [PW-1:0] shifted;
    logic [PW-1:0] lim;
    logic [PW-1:0] clipped;
    logic          ovf;
    logic signed [STATE_WIDTH-1:0] r_res;
    logic          r_done;
    logic          r_clip;

    assign mag_a = i_a[OW-1] ? OW'(-i_a) : OW'(i_a);
    assign mag_b = i_b[OW-1] ? OW'(-i_b) : OW'(i_b);

    always_comb begin
        shifted = r_prod >> FRAC_BITS;
        lim     = (PW'(1) << (STATE_WIDTH - 1)) - PW'(!r_neg);
        ovf     = shifted > lim;
        clipped = ovf ? lim : shifted;
    end

    always_ff @(posedge i_clk) begin
        r_prod <= PW'(mag_a) * PW'(mag_b);
        r_neg  <= i_a[OW-1] ^ i_b[OW-1];
        r_res  <= r_neg ? -signed'(clipped[STATE_WIDTH-1:0])
                        : signed'(clipped[STATE_WIDTH-1:0]);
        r_clip <= ovf;
        if (!i_rst_n) begin
            r_vld1 <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_vld1 <= i_start;
            r_done <= r_vld1;
        end
    end

    assign o_res       = r_res;
    assign o_stat.done = r_done;
    assign o_stat.clip = r_clip;
endmodule
`default_nettype wire

### rtl/core/lrk4_div6.sv
// Three-lane digit-serial divider by six for the RK4 update
`default_nettype none
module lrk4_div6 #(
    parameter int AW = 35
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_start,
    input  wire logic [AW-1:0] i_mag [3],
    output logic [AW-1:0]      o_q [3],
    output logic               o_done
);
    import lrk4_pkg::*;

    localparam int DW = 8;
    localparam int NB = (AW + DW - 1) / DW;
    localparam int PW = NB * DW;
    localparam int CW = $clog2(NB + 1);
    // floor(x * 1366 / 2^13) equals floor(x / 6) for every x below 2048
    localparam logic [10:0] RECIP = 11'd1366;

    logic [PW-1:0] r_q [3];
    logic [2:0]    r_r [3];
    logic [CW-1:0] r_cnt;
    logic          r_busy;
    logic          r_done;
    logic [10:0]   cur  [3];
    logic [21:0]   prod [3];
    logic [7:0]    qd   [3];
    logic [10:0]   rem  [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            cur[i]  = {r_r[i], r_q[i][PW-1 -: DW]};
            prod[i] = 22'(cur[i]) * 22'(RECIP);
            qd[i]   = prod[i][20:13];
            rem[i]  = cur[i] - 11'(qd[i]) * 11'd6;
            o_q[i]  = r_q[i][AW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            for (int i = 0; i < 3; i++) begin
                r_q[i] <= PW'(i_mag[i]);
                r_r[i] <= 3'd0;
            end
        end else if (r_busy) begin
            for (int i = 0; i < 3; i++) begin
                r_q[i] <= {r_q[i][PW-DW-1:0], qd[i]};
                r_r[i] <= rem[i][2:0];
            end
        end
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(NB);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CW'(1);
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
endmodule
`default_nettype wire

### rtl/core/lorenz_rk4_integrator.sv
// Lorenz system RK4 integrator: sequencer, state and I/O registers
// A step transaction holds the block from acceptance to the next acceptance: each
// of the 28 multiplies of the four RK4 stages passes an issue state and a wait on
// the shared multiplier (registered product, then registered result), then a state
// starts the divide by six, the divider works digit by digit and signals done, an
// update state writes the new state and the idle state accepts. A load transaction
// is applied at acceptance. Input is accepted only while idle and no sample is
// waiting for the output register, so a stalled output holds off the next
// transaction; an emitted sample is the state before the step, taken at
// acceptance.
`default_nettype none
module lorenz_rk4_integrator #(
    parameter int FRAC_BITS   = lrk4_pkg::FRAC_BITS_DEF,
    parameter int STATE_WIDTH = lrk4_pkg::STATE_WIDTH_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [95:0] s_axis_tdata,   // load_x, load_y, load_z
    input  wire logic        s_axis_tuser,   // action
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [95:0]      m_axis_tdata,   // sample_x, sample_y, sample_z
    output logic             m_axis_tuser,   // saturated
    input  wire logic        i_cfg_we,
    input  wire logic [2:0]  i_cfg_idx,
    input  wire logic [30:0] i_cfg_data
);
    import lrk4_pkg::*;

    localparam int W  = STATE_WIDTH;
    localparam int OW = (W > 32) ? W : 32;
    localparam int XW = OW + 4;
    localparam int AW = W + 3;

    localparam logic signed [XW-1:0] SMAX = signed'({{(XW-W+1){1'b0}}, {(W-1){1'b1}}});
    localparam logic signed [XW-1:0] SMIN = ~SMAX;
    localparam logic signed [XW-1:0] OMAX = signed'(XW'(32'h7FFF_FFFF));
    localparam logic signed [XW-1:0] OMIN = ~OMAX;

    localparam logic [2:0] OP_DX = 3'd0;
    localparam logic [2:0] OP_DY = 3'd1;
    localparam logic [2:0] OP_XY = 3'd2;
    localparam logic [2:0] OP_BZ = 3'd3;
    localparam logic [2:0] OP_KX = 3'd4;
    localparam logic [2:0] OP_KY = 3'd5;
    localparam logic [2:0] OP_KZ = 3'd6;

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_ISSUE = 6'b000010,
        ST_WAIT  = 6'b000100,
        ST_DIVGO = 6'b001000,
        ST_DIV   = 6'b010000,
        ST_UPD   = 6'b100000
    } t_state;

    function automatic logic signed [W-1:0] f_sat(input logic signed [XW-1:0] v);
        logic signed [XW-1:0] c;
        c = (v > SMAX) ? SMAX : ((v < SMIN) ? SMIN : v);
        return c[W-1:0];
    endfunction

    function automatic logic f_ovf(input logic signed [XW-1:0] v);
        return (v > SMAX) || (v < SMIN);
    endfunction

    function automatic logic [31:0] f_out32(input logic signed [W-1:0] x);
        logic signed [XW-1:0] v;
        v = XW'(x);
        v = (v > OMAX) ? OMAX : ((v < OMIN) ? OMIN : v);
        return v[31:0];
    endfunction

    t_state r_state;
    logic [20:0] r_h;
    logic [30:0] r_sigma;
    logic [30:0] r_rho;
    logic [30:0] r_beta;
    logic [15:0] r_intv;
    logic signed [W-1:0]  r_a   [3];
    logic signed [W-1:0]  r_t   [3];
    logic signed [W-1:0]  r_d   [3];
    logic signed [AW-1:0] r_acc [3];
    logic signed [W-1:0]  r_m;
    logic [15:0] r_phase;
    logic        r_clip;
    logic        r_clip_now;
    logic [1:0]  r_stg;
    logic [2:0]  r_op;
    logic        r_pend_vld;
    logic [95:0] r_pend_data;
    logic        r_pend_sat;
    logic        r_out_vld;
    logic [95:0] r_out_data;
    logic        r_out_sat;

    logic        in_acc;
    logic [16:0] n_phase;
    logic signed [OW-1:0] op_a;
    logic signed [OW-1:0] op_b;
    logic        clip_iss;
    logic signed [XW-1:0] diff_yx;
    logic signed [XW-1:0] diff_rz;
    logic signed [W-1:0]  mres;
    t_mul_stat   mstat;
    logic [1:0]  li;
    logic signed [XW-1:0] kx;
    logic signed [XW-1:0] khalf;
    logic signed [XW-1:0] tsum;
    logic signed [AW-1:0] kw;
    logic signed [XW-1:0] d1sum;
    logic signed [XW-1:0] d2sum;
    logic        wait_ovf;
    logic [AW-1:0] div_mag [3];
    logic [AW-1:0] div_q   [3];
    logic          div_done;
    logic signed [XW-1:0] upd_sum [3];
    logic signed [W-1:0]  ld_val  [3];

    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (r_state == ST_IDLE) && !r_pend_vld;
    assign n_phase       = {1'b0, r_phase} + 17'd1;

    always_comb begin
        diff_yx  = XW'(r_t[1]) - XW'(r_t[0]);
        diff_rz  = signed'(XW'(r_rho)) - XW'(r_t[2]);
        op_a     = '0;
        op_b     = '0;
        clip_iss = 1'b0;
        case (r_op)
            OP_DX: begin
                op_a     = signed'(OW'(r_sigma));
                op_b     = OW'(f_sat(diff_yx));
                clip_iss = f_ovf(diff_yx);
            end
            OP_DY: begin
                op_a     = OW'(r_t[0]);
                op_b     = OW'(f_sat(diff_rz));
                clip_iss = f_ovf(diff_rz);
            end
            OP_XY: begin
                op_a = OW'(r_t[0]);
                op_b = OW'(r_t[1]);
            end
            OP_BZ: begin
                op_a = signed'(OW'(r_beta));
                op_b = OW'(r_t[2]);
            end
            OP_KX: begin
                op_a = signed'(OW'(r_h));
                op_b = OW'(r_d[0]);
            end
            OP_KY: begin
                op_a = signed'(OW'(r_h));
                op_b = OW'(r_d[1]);
            end
            OP_KZ: begin
                op_a = signed'(OW'(r_h));
                op_b = OW'(r_d[2]);
            end
            default: begin
                op_a = '0;
                op_b = '0;
            end
        endcase
    end

    lrk4_mul #(
        .FRAC_BITS  (FRAC_BITS),
        .STATE_WIDTH(W),
        .OW         (OW)
    ) u_mul (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(r_state == ST_ISSUE),
        .i_a    (op_a),
        .i_b    (op_b),
        .o_res  (mres),
        .o_stat (mstat)
    );

    always_comb begin
        li    = 2'(r_op - OP_KX);
        kx    = XW'(mres);
        khalf = (kx + signed'(XW'(kx[XW-1]))) >>> 1;
        tsum  = XW'(r_a[li]) + ((r_stg < 2'd2) ? khalf : kx);
        kw    = ((r_stg == 2'd1) || (r_stg == 2'd2)) ? (AW'(mres) <<< 1) : AW'(mres);
        d1sum = XW'(mres) - XW'(r_t[1]);
        d2sum = XW'(r_m) - XW'(mres);
        case (r_op)
            OP_DY:               wait_ovf = f_ovf(d1sum);
            OP_BZ:               wait_ovf = f_ovf(d2sum);
            OP_KX, OP_KY, OP_KZ: wait_ovf = (r_stg != 2'd3) && f_ovf(tsum);
            default:             wait_ovf = 1'b0;
        endcase
        for (int i = 0; i < 3; i++) begin
            div_mag[i] = r_acc[i][AW-1] ? AW'(-r_acc[i]) : AW'(r_acc[i]);
            upd_sum[i] = XW'(r_a[i]) + (r_acc[i][AW-1] ? -XW'(div_q[i]) : XW'(div_q[i]));
            ld_val[i]  = f_sat(XW'(signed'(s_axis_tdata[32*i +: 32])));
        end
    end

    lrk4_div6 #(
        .AW(AW)
    ) u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(r_state == ST_DIVGO),
        .i_mag  (div_mag),
        .o_q    (div_q),
        .o_done (div_done)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_h        <= STEP_RST;
            r_sigma    <= SIGMA_RST;
            r_rho      <= RHO_RST;
            r_beta     <= BETA_RST;
            r_intv     <= INTV_RST;
            r_a[0]     <= W'(POS_X_RST);
            r_a[1]     <= W'(POS_Y_RST);
            r_a[2]     <= W'(POS_Z_RST);
            r_phase    <= '0;
            r_clip     <= 1'b0;
            r_clip_now <= 1'b0;
            r_stg      <= '0;
            r_op       <= '0;
            r_pend_vld <= 1'b0;
            r_out_vld  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_STEP:  r_h     <= i_cfg_data[20:0];
                    CFG_SIGMA: r_sigma <= i_cfg_data;
                    CFG_RHO:   r_rho   <= i_cfg_data;
                    CFG_BETA:  r_beta  <= i_cfg_data;
                    CFG_INTV:  r_intv  <= i_cfg_data[15:0];
                    default: ;
                endcase
            end

            if (r_pend_vld && (!r_out_vld || m_axis_tready)) begin
                r_out_vld  <= 1'b1;
                r_out_data <= r_pend_data;
                r_out_sat  <= r_pend_sat;
                r_pend_vld <= 1'b0;
            end else if (m_axis_tready) begin
                r_out_vld <= 1'b0;
            end

            case (r_state)
                ST_IDLE: begin
                    if (in_acc) begin
                        if (s_axis_tuser == ACT_LOAD) begin
                            for (int i = 0; i < 3; i++) r_a[i] <= ld_val[i];
                            r_phase <= '0;
                            r_clip  <= 1'b0;
                        end else begin
                            if (r_phase == '0) begin
                                r_pend_vld  <= 1'b1;
                                r_pend_data <= {f_out32(r_a[2]), f_out32(r_a[1]),
                                                f_out32(r_a[0])};
                                r_pend_sat  <= r_clip;
                            end
                            r_phase <= ((n_phase[15:0] >= r_intv) || (n_phase[15:0] == '0))
                                       ? '0 : n_phase[15:0];
                            for (int i = 0; i < 3; i++) r_t[i] <= r_a[i];
                            r_clip_now <= 1'b0;
                            r_stg      <= '0;
                            r_op       <= OP_DX;
                            r_state    <= ST_ISSUE;
                        end
                    end
                end
                ST_ISSUE: begin
                    if (clip_iss) r_clip_now <= 1'b1;
                    r_state <= ST_WAIT;
                end
                ST_WAIT: begin
                    if (mstat.done) begin
                        r_clip_now <= r_clip_now || mstat.clip || wait_ovf;
                        case (r_op)
                            OP_DX: r_d[0] <= mres;
                            OP_DY: r_d[1] <= f_sat(d1sum);
                            OP_XY: r_m <= mres;
                            OP_BZ: r_d[2] <= f_sat(d2sum);
                            default: begin
                                r_acc[li] <= ((r_stg == 2'd0) ? AW'(0) : r_acc[li]) + kw;
                                if (r_stg != 2'd3) r_t[li] <= f_sat(tsum);
                            end
                        endcase
                        if (r_op == OP_KZ) begin
                            r_op  <= OP_DX;
                            r_stg <= r_stg + 2'd1;
                            r_state <= (r_stg == 2'd3) ? ST_DIVGO : ST_ISSUE;
                        end else begin
                            r_op    <= r_op + 3'd1;
                            r_state <= ST_ISSUE;
                        end
                    end
                end
                ST_DIVGO: r_state <= ST_DIV;
                ST_DIV: begin
                    if (div_done) r_state <= ST_UPD;
                end
                ST_UPD: begin
                    for (int i = 0; i < 3; i++) r_a[i] <= f_sat(upd_sum[i]);
                    r_clip  <= r_clip_now || f_ovf(upd_sum[0]) || f_ovf(upd_sum[1])
                               || f_ovf(upd_sum[2]);
                    r_state <= ST_IDLE;
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_sat;

    a_mul_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mstat.done |-> r_state == ST_WAIT)
        else $error("multiplier result outside wait state");

    a_div_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> r_state == ST_DIV)
        else $error("divider result outside divide state");

    a_issue_then_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_ISSUE |=> r_state == ST_WAIT)
        else $error("issue not followed by wait");

    a_busy_no_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state != ST_IDLE |-> !s_axis_tready)
        else $error("ready raised during a step");
endmodule
`default_nettype wire

### tb/tb_lorenz_rk4_integrator.sv
// Self-checking testbench for the Lorenz RK4 integrator: directed table, then random streams
`default_nettype none
module tb_lorenz_rk4_integrator;
    import lrk4_pkg::*;

    localparam int          CYCLE_LIMIT = 2000000;
    localparam int          SETTLE      = 300;
    localparam logic [2:0]  CFG_UNUSED  = 3'd7;
    localparam longint      SMAX        = 64'sd2147483647;
    localparam longint      SMIN        = -64'sd2147483648;

    typedef struct {
        logic              act;
        logic signed [31:0] x, y, z;
        bit                known;
        logic signed [31:0] ex, ey, ez;
        logic              es;
    } t_row;

    typedef struct {
        logic signed [31:0] x, y, z;
        logic              sat;
    } t_sample;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [95:0] s_axis_tdata = '0;
    logic        s_axis_tuser = ACT_STEP;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [95:0] m_axis_tdata;
    logic        m_axis_tuser;
    logic        i_cfg_we = 1'b0;
    logic [2:0]  i_cfg_idx = '0;
    logic [30:0] i_cfg_data = '0;

    lorenz_rk4_integrator uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data)
    );

    // model copy of the integrator
    logic [20:0]        h_reg;
    logic [30:0]        sigma_reg, rho_reg, beta_reg;
    logic [15:0]        intv_reg, phase;
    longint             px, py, pz;
    logic               clip_flag;
    bit                 clip_now;

    t_sample            sample_q[$];
    int                 mismatches = 0;
    int                 samples_seen = 0;
    int                 items_sent = 0;
    int                 loads_sent = 0;
    int                 burst_left = 0;
    int                 cycles = 0;

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    function automatic longint sat(input longint v);
        if (v > SMAX) begin clip_now = 1; return SMAX; end
        if (v < SMIN) begin clip_now = 1; return SMIN; end
        return v;
    endfunction

    function automatic longint qmul(input longint a, input longint b);
        bit     neg;
        longint ua, ub, res, lim;
        neg = (a < 0) != (b < 0);
        ua  = (a < 0) ? -a : a;
        ub  = (b < 0) ? -b : b;
        res = (ua * ub) >>> FRAC_BITS_DEF;
        lim = neg ? SMAX + 1 : SMAX;
        if (res > lim) begin clip_now = 1; res = lim; end
        return neg ? -res : res;
    endfunction

    function automatic void lorenz_stage(input longint vx, vy, vz,
                                         output longint kx, ky, kz);
        longint dx, dy, dz;
        dx = qmul(longint'(sigma_reg), sat(vy - vx));
        dy = sat(qmul(vx, sat(longint'(rho_reg) - vz)) - vy);
        dz = sat(qmul(vx, vy) - qmul(longint'(beta_reg), vz));
        kx = qmul(longint'(h_reg), dx);
        ky = qmul(longint'(h_reg), dy);
        kz = qmul(longint'(h_reg), dz);
    endfunction

    function automatic void rk4_advance();
        longint k1x, k1y, k1z, k2x, k2y, k2z, k3x, k3y, k3z, k4x, k4y, k4z;
        lorenz_stage(px, py, pz, k1x, k1y, k1z);
        lorenz_stage(sat(px + k1x / 2), sat(py + k1y / 2), sat(pz + k1z / 2), k2x, k2y, k2z);
        lorenz_stage(sat(px + k2x / 2), sat(py + k2y / 2), sat(pz + k2z / 2), k3x, k3y, k3z);
        lorenz_stage(sat(px + k3x), sat(py + k3y), sat(pz + k3z), k4x, k4y, k4z);
        px = sat(px + (k1x + 2 * k2x + 2 * k3x + k4x) / 6);
        py = sat(py + (k1y + 2 * k2y + 2 * k3y + k4y) / 6);
        pz = sat(pz + (k1z + 2 * k2z + 2 * k3z + k4z) / 6);
    endfunction

    // returns 1 and the sample when the item emits one
    function automatic bit integrate_item(input logic act, input logic [95:0] d,
                                          output t_sample s);
        bit emit;
        emit = 0;
        s = '{default: '0};
        if (act == ACT_LOAD) begin
            px = longint'($signed(d[31:0]));
            py = longint'($signed(d[63:32]));
            pz = longint'($signed(d[95:64]));
            phase = '0;
            clip_flag = 1'b0;
            return 0;
        end
        if (phase == 0) begin
            s = '{x: px[31:0], y: py[31:0], z: pz[31:0], sat: clip_flag};
            emit = 1;
        end
        clip_now = 0;
        rk4_advance();
        clip_flag = clip_now;
        phase = phase + 16'd1;
        if (phase >= intv_reg || phase == 0) phase = '0;
        return emit;
    endfunction

    task automatic report(input string what, input t_sample got, input t_sample want);
        mismatches++;
        $display("MISMATCH %s: got %h %h %h %b want %h %h %h %b", what,
                 got.x, got.y, got.z, got.sat, want.x, want.y, want.z, want.sat);
    endtask

    task automatic cfg_write(input t_cfg_idx idx, input logic [30:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        case (idx)
            CFG_STEP:  h_reg     = val[20:0];
            CFG_SIGMA: sigma_reg = val;
            CFG_RHO:   rho_reg   = val;
            CFG_BETA:  beta_reg  = val;
            CFG_INTV:  intv_reg  = val[15:0];
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    task automatic configure(input logic [30:0] h, sg, rh, bt, iv);
        wait (sample_q.size() == 0);
        repeat (SETTLE) @(posedge i_clk);
        cfg_write(CFG_STEP, h);
        cfg_write(CFG_SIGMA, sg);
        cfg_write(CFG_RHO, rh);
        cfg_write(CFG_BETA, bt);
        cfg_write(CFG_INTV, iv);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_UNUSED;
        i_cfg_data <= 31'($urandom);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic send_item(input logic act, input logic [95:0] d,
                             input bit known, input t_sample typed);
        int      gap;
        t_sample s;
        gap = 0;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 8);
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= d;
        s_axis_tuser  <= act;
        do @(posedge i_clk); while (!s_axis_tready);
        items_sent++;
        if (act == ACT_LOAD) loads_sent++;
        if (integrate_item(act, d, s)) sample_q.push_back(known ? typed : s);
    endtask

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(0, 3))
            0:       return $urandom;
            1:       return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            default: return 32'($signed($urandom_range(0, 60 << 20)) - (30 << 20));
        endcase
    endfunction

    task automatic random_items(input int n, input int load_pct);
        t_sample none;
        none = '{default: '0};
        repeat (n) begin
            if ($urandom_range(0, 99) < load_pct)
                send_item(ACT_LOAD, {rand_coord(), rand_coord(), rand_coord()}, 0, none);
            else
                send_item(ACT_STEP, {$urandom, $urandom, $urandom}, 0, none);
        end
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
    endtask

    // receiver stall pattern: one of four tready modes, chosen at random and redrawn over the run
    int stall_mode = 0;
    always @(posedge i_clk) begin
        if (cycles % 400 == 0) stall_mode <= $urandom_range(0, 3);
        case (stall_mode)
            0:       m_axis_tready <= 1'b1;
            1:       m_axis_tready <= $urandom_range(0, 1);
            2:       m_axis_tready <= (cycles % 7) < 3;
            default: m_axis_tready <= ($urandom_range(0, 9) == 0);
        endcase
    end

    always @(posedge i_clk) begin
        t_sample got, want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = '{x: m_axis_tdata[31:0], y: m_axis_tdata[63:32],
                    z: m_axis_tdata[95:64], sat: m_axis_tuser};
            samples_seen++;
            if (sample_q.size() == 0) begin
                report("unexpected sample", got, got);
            end else begin
                want = sample_q.pop_front();
                if (got.x !== want.x || got.y !== want.y || got.z !== want.z ||
                    got.sat !== want.sat)
                    report("sample", got, want);
            end
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles", cycles);
            $display("Mismatches found");
            $finish;
        end
    end

    t_row rows[] = '{
        '{ACT_STEP, 32'h0, 32'h0, 32'h0, 1, POS_X_RST, POS_Y_RST, POS_Z_RST, 1'b0},
        '{ACT_STEP, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 0, 0, 0, 0},
        '{ACT_LOAD, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 0, 0, 0, 0},
        '{ACT_STEP, 32'h0, 32'h0, 32'h0, 1, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0},
        '{ACT_STEP, 32'h0, 32'h0, 32'h0, 0, 0, 0, 0, 0},
        '{ACT_STEP, 32'h0, 32'h0, 32'h0, 0, 0, 0, 0, 0},
        '{ACT_LOAD, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0, 0, 0, 0, 0},
        '{ACT_STEP, 32'h0, 32'h0, 32'h0, 1, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b0},
        '{ACT_STEP, 32'h0, 32'h0, 32'h0, 0, 0, 0, 0, 0},
        '{ACT_LOAD, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 0, 0, 0, 0, 0},
        '{ACT_STEP, 32'h0, 32'h0, 32'h0, 1, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0},
        '{ACT_STEP, 32'h0, 32'h0, 32'h0, 0, 0, 0, 0, 0},
        '{ACT_LOAD, 32'h0, 32'h0, 32'h0, 0, 0, 0, 0, 0},
        '{ACT_STEP, 32'h0, 32'h0, 32'h0, 1, 32'h0, 32'h0, 32'h0, 1'b0},
        '{ACT_STEP, 32'h0, 32'h0, 32'h0, 1, 32'h0, 32'h0, 32'h0, 1'b0},
        '{ACT_LOAD, 32'hAAAA_AAAA, 32'h5555_5555, 32'hFFFF_FFFF, 0, 0, 0, 0, 0},
        '{ACT_STEP, 32'h0, 32'h0, 32'h0, 1, 32'hAAAA_AAAA, 32'h5555_5555, 32'hFFFF_FFFF, 1'b0},
        '{ACT_STEP, 32'h0, 32'h0, 32'h0, 0, 0, 0, 0, 0},
        '{ACT_LOAD, 32'h0010_0000, 32'h0008_0000, 32'hFFFB_3333, 0, 0, 0, 0, 0},
        '{ACT_STEP, 32'h0, 32'h0, 32'h0, 0, 0, 0, 0, 0},
        '{ACT_STEP, 32'h0, 32'h0, 32'h0, 0, 0, 0, 0, 0}
    };

    initial begin
        t_sample typed;
        h_reg = STEP_RST; sigma_reg = SIGMA_RST; rho_reg = RHO_RST;
        beta_reg = BETA_RST; intv_reg = INTV_RST;
        px = POS_X_RST; py = POS_Y_RST; pz = POS_Z_RST;
        phase = '0; clip_flag = 1'b0;

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (rows[i]) begin
            typed = '{x: rows[i].ex, y: rows[i].ey, z: rows[i].ez, sat: rows[i].es};
            send_item(rows[i].act, {rows[i].z, rows[i].y, rows[i].x}, rows[i].known, typed);
        end
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);

        configure(STEP_RST, SIGMA_RST, RHO_RST, BETA_RST, INTV_RST);
        random_items(300, 8);
        configure(31'd1048576, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 31'd1);
        random_items(150, 15);
        configure(31'd0, SIGMA_RST, RHO_RST, BETA_RST, 31'd0);
        random_items(100, 10);
        configure(31'd1, 31'd0, 31'd0, 31'd0, 31'd65535);
        random_items(60, 40);
        configure(31'($urandom_range(1, 20000)), 31'($urandom_range(0, 20 << 20)),
                  31'($urandom_range(0, 50 << 20)), 31'($urandom_range(0, 5 << 20)),
                  31'($urandom_range(1, 5)));
        random_items(700, 6);
        configure(STEP_RST, SIGMA_RST, RHO_RST, BETA_RST, 31'd3);
        random_items(700, 6);

        wait (sample_q.size() == 0);
        repeat (SETTLE) @(posedge i_clk);
        if (sample_q.size() != 0) mismatches++;
        $display("Sent %0d transactions (%0d loads) over six register settings", items_sent,
                 loads_sent);
        $display("Checked %0d samples, %0d errors", samples_seen, mismatches);
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end
endmodule
`default_nettype wire
